>>> design/slspan_pkg.sv
// Shared types and constants for the shortest/longest span store.
package slspan_pkg;

    localparam int unsigned DEFAULT_CAPACITY = 256;
    localparam int unsigned VALUE_W          = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } slspan_state_t;

endpackage

>>> design/set_shortest_longest_span.sv
// Top level: signed value store reporting shortest gap and full range per transaction.
//
// Usage
//   Input channel (in_valid / in_ready / new_value): one transaction adds one signed
//   32-bit number to the store unless it is full. Output channel (out_valid /
//   out_ready / result fields): one transaction per input, carrying the shortest gap,
//   the longest span (largest minus smallest), spans_valid and rejected_full.
//   Sequence: with numbers already stored, a transaction first scans, reading every
//   stored entry once through the single read port of the store and feeding the
//   shared distance/compare unit; it then writes the number and updates the range,
//   and the result shows once the output register takes it. in_ready rises again
//   as the result shows, so the next number can be taken then. A full store skips
//   the scan and the write: the result shows without the number being stored.
//   in_ready is high only while the sequencer is idle, so one number is in work at a
//   time; the result sits in an output register, so the next number is taken while
//   an earlier result still waits.
//   Reset (rst_n low, asynchronous): store empty, range zero, best gap all ones, no
//   result pending. The store contents need no clearing: only written entries are read.
//   Receiver stall: the finished result waits in the sequencer until the output
//   register frees up; nothing is lost or repeated.
module set_shortest_longest_span #(
    parameter int unsigned CAPACITY = slspan_pkg::DEFAULT_CAPACITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [slspan_pkg::VALUE_W-1:0] new_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [slspan_pkg::VALUE_W-1:0]  shortest_span,
    output logic [slspan_pkg::VALUE_W-1:0]  longest_span,
    output logic                            spans_valid,
    output logic                            rejected_full
);

    localparam int unsigned VW = slspan_pkg::VALUE_W;
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // store address
    localparam int unsigned CW = $clog2(CAPACITY + 1);                     // fill count

    // sequencer
    slspan_pkg::slspan_state_t st_reg, st_next;

    // control registers
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  idx_reg;
    logic           rd_pend_reg;     // rd_data_reg holds fresh read data this cycle
    logic           dist_vld_reg;    // dist_reg holds a fresh distance
    logic [VW-1:0]  best_gap_reg;
    logic [VW-1:0]  smallest_reg;
    logic [VW-1:0]  largest_reg;
    logic           out_valid_reg;

    // payload registers
    logic [VW-1:0]  value_reg;
    logic           rejected_reg;
    logic [VW-1:0]  rd_data_reg;
    logic [VW-1:0]  dist_reg;
    logic [VW-1:0]  shortest_reg;
    logic [VW-1:0]  longest_reg;
    logic           spans_valid_reg;
    logic           rejected_out_reg;

    // the store: one write port, one registered read port
    logic [VW-1:0]  value_store [CAPACITY];

    // control decode
    logic           in_acc;
    logic           store_full;
    logic           store_rd;
    logic           store_wr;
    logic           scan_done;
    logic           out_load;

    // shared distance unit
    logic           rd_lt;
    logic [VW-1:0]  dist_calc;

    // result formation
    logic           res_valid;

    assign store_full = (count_reg == CW'(CAPACITY));
    assign in_acc     = in_valid && in_ready;

    // Distance between the new value and the entry just read; wrap-around
    // subtraction of the larger minus the smaller is exact over the signed range.
    assign rd_lt     = $signed(rd_data_reg) < $signed(value_reg);
    assign dist_calc = rd_lt ? (value_reg - rd_data_reg) : (rd_data_reg - value_reg);

    assign res_valid = (count_reg >= CW'(2));

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            slspan_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = store_full ? slspan_pkg::ST_RESULT : slspan_pkg::ST_SCAN;
                end
            end
            slspan_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    st_next = slspan_pkg::ST_UPDATE;
                end
            end
            slspan_pkg::ST_UPDATE:
            begin
                st_next = slspan_pkg::ST_RESULT;
            end
            slspan_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    st_next = slspan_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = slspan_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs of sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        store_rd  = 1'b0;
        store_wr  = 1'b0;
        scan_done = 1'b0;
        out_load  = 1'b0;
        unique case (st_reg)
            slspan_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            slspan_pkg::ST_SCAN:
            begin
                store_rd  = (idx_reg < count_reg);
                // last read issued, last read data consumed, last distance compared
                scan_done = !store_rd && !rd_pend_reg && !dist_vld_reg;
            end
            slspan_pkg::ST_UPDATE:
            begin
                store_wr = 1'b1;
            end
            slspan_pkg::ST_RESULT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- store
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            value_store[count_reg[AW-1:0]] <= value_reg;
        end
        if (store_rd)
        begin
            rd_data_reg <= value_store[idx_reg[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= slspan_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            dist_vld_reg  <= 1'b0;
            best_gap_reg  <= '1;
            smallest_reg  <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            rd_pend_reg  <= store_rd;
            dist_vld_reg <= rd_pend_reg;

            if (in_acc)
            begin
                idx_reg <= '0;
            end
            else if (store_rd)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            if (dist_vld_reg && (dist_reg < best_gap_reg))
            begin
                best_gap_reg <= dist_reg;
            end

            if (store_wr)
            begin
                count_reg <= count_reg + CW'(1);
                if (count_reg == '0)
                begin
                    smallest_reg <= value_reg;
                    largest_reg  <= value_reg;
                end
                else
                begin
                    if ($signed(value_reg) < $signed(smallest_reg))
                    begin
                        smallest_reg <= value_reg;
                    end
                    if ($signed(value_reg) > $signed(largest_reg))
                    begin
                        largest_reg <= value_reg;
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            value_reg    <= new_value;
            rejected_reg <= store_full;
        end
        if (rd_pend_reg)
        begin
            dist_reg <= dist_calc;
        end
        if (out_load)
        begin
            shortest_reg     <= res_valid ? best_gap_reg : '0;
            longest_reg      <= res_valid ? (largest_reg - smallest_reg) : '0;
            spans_valid_reg  <= res_valid;
            rejected_out_reg <= rejected_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shortest_span = shortest_reg;
    assign longest_span  = longest_reg;
    assign spans_valid   = spans_valid_reg;
    assign rejected_full = rejected_out_reg;

endmodule

>>> design/slspan_chk.sv
// Port-level checker for the span store, bound to the top level.
module slspan_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [slspan_pkg::VALUE_W-1:0] new_value,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [slspan_pkg::VALUE_W-1:0] shortest_span,
    input logic [slspan_pkg::VALUE_W-1:0] longest_span,
    input logic                           spans_valid,
    input logic                           rejected_full
);

    // not ready in the cycle after taking a number
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // spans are reported as zero until two numbers are held
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !spans_valid |-> shortest_span == '0 && longest_span == '0)
        else $error("non-zero span without two stored numbers");

    // a full store holds at least two numbers when CAPACITY is two or more
    a_reject_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected_full |-> spans_valid)
        else $error("rejection reported with fewer than two numbers");

    // the smallest gap never exceeds the full range
    a_gap_within_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spans_valid |-> shortest_span <= longest_span)
        else $error("shortest span exceeds longest span");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(shortest_span)
            && $stable(longest_span) && $stable(spans_valid) && $stable(rejected_full))
        else $error("result changed while stalled");

endmodule

bind set_shortest_longest_span slspan_chk u_slspan_chk (.*);
